// ===== hw/rtl/rme_pkg.sv =====
`default_nettype none
package rme_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;
  localparam int MAT_W             = 16;
  localparam int SUM_W             = 32;
  localparam int ROOT_W            = 16;
  localparam int REM_W             = ROOT_W + 3;
  localparam int OPD_W             = MAT_W + 1;
  localparam int CW                = 27;
  localparam int OUT_W             = 16;
  localparam int THR_W             = 15;

  localparam logic signed [CW-1:0] HALF_TURN   = 27'sd11796480;
  localparam logic signed [CW-1:0] ANGLE_LIMIT = 27'sd23040;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [CW-1:0] atan_deg16(input int unsigned i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 27'sd2949120;
      1:  v = 27'sd1740967;
      2:  v = 27'sd919879;
      3:  v = 27'sd466945;
      4:  v = 27'sd234379;
      5:  v = 27'sd117304;
      6:  v = 27'sd58666;
      7:  v = 27'sd29335;
      8:  v = 27'sd14668;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_euler_angles_core.sv =====
// pipeline: CORDIC_STAGES + 21 register stages from in_tdata to out_tdata
// (3 front stages, 16 square-root stages, 1 prerotation, CORDIC stages, 1 rounding)
// throughput: one matrix per cycle, a single enable stalls the whole pipeline
// reset: synchronous active-low rst_n clears valid bits, threshold resets to 1
`default_nettype none
module rotation_matrix_to_euler_angles_core #(
  parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // r00, r10, r20, r21, r22, r11, r12 (16 bits each)
  input  wire logic [111:0]                  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // angle_x, angle_y, angle_z (16 bits each)
  output logic [47:0]                        out_tdata,
  // is_singular
  output logic                               out_tuser,
  input  wire logic                          cfg_we,
  input  wire logic [rme_pkg::THR_W-1:0]     cfg_wdata
);
  localparam int NB  = rme_pkg::ROOT_W;
  localparam int MW  = rme_pkg::MAT_W;
  localparam int OW  = rme_pkg::OPD_W;
  localparam int CW  = rme_pkg::CW;
  localparam int LAT = NB + CORDIC_STAGES + 5;
  localparam int RW  = CW - 9;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [rme_pkg::THR_W-1:0] thr_r;

  logic [111:0] in_r;
  logic [111:0] m_r [0:NB+1];
  logic [rme_pkg::SUM_W-1:0] sq00_r, sq10_r, sum_r;
  logic [NB-1:0] root;

  logic sing_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] ax, ay, az;
  logic zx, zy, zz;
  logic [47:0] out_data_r;
  logic out_sing_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= rme_pkg::THR_W'(1);
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // squares, then sum
  logic signed [2*MW-1:0] p00, p10;
  assign p00 = $signed(in_r[15:0]) * $signed(in_r[15:0]);
  assign p10 = $signed(in_r[31:16]) * $signed(in_r[31:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      in_r   <= in_tdata;
      m_r[0] <= in_r;
      sq00_r <= rme_pkg::SUM_W'(p00);
      sq10_r <= rme_pkg::SUM_W'(p10);
      m_r[1] <= m_r[0];
      sum_r  <= sq00_r + sq10_r;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_mdly
    always_ff @(posedge clk) begin
      if (en) m_r[k+2] <= m_r[k+1];
    end
  end

  rme_isqrt u_isqrt (.clk(clk), .en(en), .sum(sum_r), .root(root));

  // operand selection
  logic [111:0] mq;
  logic sing;
  logic signed [OW-1:0] xy_y, xy_x, yy_y, yy_x, zy_y, zy_x;
  always_comb begin
    mq   = m_r[NB+1];
    sing = {1'b0, root} < (NB+1)'(thr_r);
    xy_y = sing ? -OW'($signed(mq[111:96])) : OW'($signed(mq[63:48]));
    xy_x = sing ?  OW'($signed(mq[95:80]))  : OW'($signed(mq[79:64]));
    yy_y = -OW'($signed(mq[47:32]));
    yy_x = $signed({1'b0, root});
    zy_y = OW'($signed(mq[31:16]));
    zy_x = OW'($signed(mq[15:0]));
  end

  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cx (
    .clk(clk), .en(en), .y_in(xy_y), .x_in(xy_x), .angle(ax), .zero(zx));
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cy (
    .clk(clk), .en(en), .y_in(yy_y), .x_in(yy_x), .angle(ay), .zero(zy));
  rme_cordic #(.STAGES(CORDIC_STAGES)) u_cz (
    .clk(clk), .en(en), .y_in(zy_y), .x_in(zy_x), .angle(az), .zero(zz));

  always_ff @(posedge clk) begin
    if (en) sing_r[0] <= sing;
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (en) sing_r[i+1] <= sing_r[i];
    end
  end

  function automatic logic [rme_pkg::OUT_W-1:0] round_clamp(
    input logic signed [CW-1:0] a, input logic z);
    logic signed [CW-1:0] s;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] lim;
    s   = (a + CW'(256)) >>> 9;
    r   = RW'(s);
    lim = RW'(rme_pkg::ANGLE_LIMIT);
    if (z) r = '0;
    else if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return rme_pkg::OUT_W'(r);
  endfunction

  logic last_sing;
  assign last_sing = sing_r[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r[15:0]  <= round_clamp(ax, zx);
      out_data_r[31:16] <= round_clamp(ay, zy);
      out_data_r[47:32] <= round_clamp(az, zz || last_sing);
      out_sing_r        <= last_sing;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sing_r;

  a_sing_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:32] == '0)
    else $error("angle_z not zero in singular case");
  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040 &&
                    $signed(out_tdata[15:0]) >= -16'sd23040))
    else $error("angle_x out of range");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
endmodule
`default_nettype wire

// ===== hw/rtl/rme_isqrt.sv =====
`default_nettype none
module rme_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [rme_pkg::SUM_W-1:0]     sum,
  output logic      [rme_pkg::ROOT_W-1:0]    root
);
  localparam int NB = rme_pkg::ROOT_W;
  localparam int RW = rme_pkg::REM_W;
  localparam int SW = rme_pkg::SUM_W;

  logic [RW-1:0] rem_r  [0:NB-1];
  logic [NB-1:0] root_r [0:NB-1];
  logic [SW-1:0] n_r    [0:NB-1];

  // one result bit per stage, restoring digit recurrence
  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [RW-1:0] rem_p, cat, test, rem_nxt;
    logic [NB-1:0] root_p, root_nxt;
    logic [SW-1:0] n_p;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = sum;
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign n_p    = n_r[k-1];
    end
    always_comb begin
      cat  = {rem_p[RW-3:0], n_p[SW-1:SW-2]};
      test = RW'({root_p, 2'b01});
      if (cat >= test) begin
        rem_nxt  = cat - test;
        root_nxt = {root_p[NB-2:0], 1'b1};
      end else begin
        rem_nxt  = cat;
        root_nxt = {root_p[NB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        n_r[k]    <= {n_p[SW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[NB-1];
endmodule
`default_nettype wire

// ===== hw/rtl/rme_cordic.sv =====
`default_nettype none
module rme_cordic #(
  parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [rme_pkg::OPD_W-1:0]  y_in,
  input  wire logic signed [rme_pkg::OPD_W-1:0]  x_in,
  output logic signed      [rme_pkg::CW-1:0]     angle,
  output logic                                   zero
);
  localparam int CW = rme_pkg::CW;

  logic signed [CW-1:0] x_r [0:STAGES];
  logic signed [CW-1:0] y_r [0:STAGES];
  logic signed [CW-1:0] z_r [0:STAGES];
  logic                 zero_r [0:STAGES];

  logic signed [CW-1:0] xs, ys;

  // prerotation into the right half plane
  always_comb begin
    xs = CW'(x_in) <<< 8;
    ys = CW'(y_in) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (xs < 0) begin
        x_r[0] <= -xs;
        y_r[0] <= -ys;
        z_r[0] <= (ys >= 0) ? rme_pkg::HALF_TURN : -rme_pkg::HALF_TURN;
      end else begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy, at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = rme_pkg::atan_deg16(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end
      end
    end
  end

  assign angle = z_r[STAGES];
  assign zero  = zero_r[STAGES];
endmodule
`default_nettype wire

// ===== tb/sv/rotation_matrix_to_euler_angles_checker.sv =====
`timescale 1ns / 1ps
module rotation_matrix_to_euler_angles_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic         out_tuser,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_count
);
  typedef struct packed {
    logic               singular;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } euler_t;

  // ring of predicted results, deeper than the pipeline
  euler_t      pred_mem [64];
  int          wr_total = 0, rd_total = 0;
  logic [14:0] threshold;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  // vectoring cordic, angle in 2^-16 degree
  function automatic longint vector_angle(longint yv, longint xv);
    longint x, y, z, dx, dy;
    x = xv * 256;
    y = yv * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < rme_pkg::CORDIC_STAGES_DEF && i < rme_pkg::ATAN_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(rme_pkg::atan_deg16(i));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(rme_pkg::atan_deg16(i));
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_degrees(longint a);
    longint r;
    r = floor_shift(a + 256, 9);
    if (r > 23040) r = 23040;
    if (r < -23040) r = -23040;
    return r[15:0];
  endfunction

  function automatic euler_t predict_angles(logic [111:0] d, logic [14:0] thr);
    longint m[7];
    longint sq, root, cand;
    euler_t e;
    for (int k = 0; k < 7; k++) m[k] = longint'($signed(d[16*k +: 16]));
    sq = m[0] * m[0] + m[1] * m[1];
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      cand = root + (longint'(1) << b);
      if (cand * cand <= sq) root = cand;
    end
    e.singular = root < longint'(thr);
    e.ay = round_degrees(vector_angle(-m[2], root));
    if (!e.singular) begin
      e.ax = round_degrees(vector_angle(m[3], m[4]));
      e.az = round_degrees(vector_angle(m[1], m[0]));
    end else begin
      e.ax = round_degrees(vector_angle(-m[6], m[5]));
      e.az = '0;
    end
    return e;
  endfunction

  assign pending_count = wr_total - rd_total;

  always @(posedge clk) begin
    euler_t want, got;
    if (!rst_n) begin
      threshold <= 15'd1;
      fail_count <= 0;
      wr_total <= 0;
      rd_total <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (in_tvalid && in_tready) begin
        pred_mem[wr_total % 64] <= predict_angles(in_tdata, threshold);
        wr_total <= wr_total + 1;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[47:32], out_tdata[31:16], out_tdata[15:0]};
        if (wr_total == rd_total) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = pred_mem[rd_total % 64];
          rd_total <= rd_total + 1;
          if (want.ax !== got.ax || want.ay !== got.ay || want.az !== got.az ||
              want.singular !== got.singular) begin
            $display("%0t: mismatch x/y/z/sing expected %0d %0d %0d %b actual %0d %0d %0d %b",
                     $time, want.ax, want.ay, want.az, want.singular,
                     got.ax, got.ay, got.az, got.singular);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/rotation_matrix_to_euler_angles_core_tb.sv =====
`timescale 1ns / 1ps
module rotation_matrix_to_euler_angles_core_tb;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_we = 0;
  logic [14:0]  cfg_wdata = '0;
  int           fail_count, pending_count;
  int           send_idle_pct = 0, recv_idle_pct = 0;
  int           quiet_cycles = 0;
  logic         timed_out = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  rotation_matrix_to_euler_angles_core dut (.*);

  rotation_matrix_to_euler_angles_checker checker_i (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 4000) timed_out <= 1;
  end

  always @(posedge timed_out) begin
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(32) - 16);
      3: return 16'($urandom);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // tvalid stays high between back-to-back transfers
  task automatic send_matrix(logic [111:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_matrix();
    logic [111:0] d;
    for (int k = 0; k < 7; k++) d[16*k +: 16] = rand_entry();
    // near gimbal lock: small r00, r10
    if ($urandom_range(5) == 0) begin
      d[15:0] = 16'($urandom_range(600) - 300);
      d[31:16] = 16'($urandom_range(600) - 300);
    end
    send_matrix(d);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [15:0] ext[6];
    ext = '{16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zeros, extremes, axis cases at reset threshold
    send_matrix('0);
    foreach (ext[i]) send_matrix({7{ext[i]}});
    send_matrix({16'h0, 16'h4000, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0});
    send_matrix({16'hC000, 16'h4000, 16'h0, 16'h0, 16'hC000, 16'h0, 16'h0});
    send_matrix({16'h4000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'hC000, 16'h0});
    send_matrix({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_matrix({7{16'h0001}});
    drain();
    write_threshold(15'h7FFF);
    send_matrix({16'h1234, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h4000, 16'h4000});
    send_matrix({7{16'h2000}});
    drain();
    write_threshold(15'd16384);
    send_matrix({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0});
    send_matrix({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000});
    drain();
    write_threshold(15'd0);
    send_matrix('0);
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      write_threshold(phase == 0 ? 15'd256 : phase == 1 ? 15'($urandom) : 15'd1);
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 75 : 0;
      recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 24 : 0;
      repeat (360) send_random_matrix();
    end
    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/rme_pkg.sv
hw/rtl/rme_isqrt.sv
hw/rtl/rme_cordic.sv
hw/rtl/rotation_matrix_to_euler_angles_core.sv
tb/sv/rotation_matrix_to_euler_angles_checker.sv
tb/sv/rotation_matrix_to_euler_angles_core_tb.sv
